// ===== src/cst_pkg.sv =====
// package: shared constants and types for the slot completion tracker
package cst_pkg;

    localparam int unsigned SLOTS_DEFAULT       = 8;
    localparam int unsigned TABLE_BYTES_DEFAULT = 256;
    localparam int unsigned CFG_INDEX_W         = 2;
    localparam int unsigned CFG_DATA_W          = 64;

    typedef enum logic [1:0] {
        ACT_SUBMIT = 2'd0,
        ACT_POLL   = 2'd1,
        ACT_STOP   = 2'd2,
        ACT_SET    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_BASE  = 2'd0,
        REG_READY = 2'd1,
        REG_UNAV  = 2'd2
    } reg_index_t;

endpackage

// ===== src/config_slot_completion_tracker.sv =====
// top level: slot completion tracker with a slot stamp memory and a sequencer
//
// Usage:
//   An input transaction is taken at a rising edge with start high and busy low.
//   The action field selects submit, poll, stop or set applied stamp.
//   Each transaction yields exactly one result, shown for one cycle with
//   result_valid high; the receiver cannot stall and must take it then.
//   Configuration registers (base address, ready marker, unavailable marker)
//   are to be written over the cfg channel (cfg_valid/cfg_ready, cfg_index,
//   cfg_data) only while the block is idle; the block does not enforce this,
//   as cfg_ready is always high. Slot stamps live in a one-port synchronous
//   memory with registered reads. A poll with done set on an active window
//   searches from the window start, then may free slots 0..end; a stop frees
//   every slot. Every operation ends with a sweep of all slots to find the
//   lowest free one. busy drops in the result cycle, so a new transaction is
//   accepted only after the previous one has finished.
//   After reset a clearing pass writes the ready marker to every slot while
//   busy is high.
module config_slot_completion_tracker #(
    parameter int unsigned SLOTS       = cst_pkg::SLOTS_DEFAULT,
    parameter int unsigned TABLE_BYTES = cst_pkg::TABLE_BYTES_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       action,
    input  logic [2:0]                       slot_index,
    input  logic [63:0]                      stamp_value,
    input  logic                             channel_done,
    input  logic [63:0]                      observed_stamp,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cst_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cst_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             result_valid,
    output logic [63:0]                      last_applied_stamp,
    output logic                             engine_active,
    output logic [2:0]                       window_start_slot,
    output logic [2:0]                       window_end_slot,
    output logic [31:0]                      window_start_address,
    output logic [31:0]                      window_end_address,
    output logic                             window_rearmed,
    output logic                             lost_track,
    output logic                             pending_at_poll,
    output logic [2:0]                       free_slot,
    output logic                             free_slot_found
);
    import cst_pkg::*;

    localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW = SW + 1;
    localparam logic [CW-1:0] LAST = CW'(SLOTS - 1);

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b00000001,
        ST_IDLE   = 8'b00000010,
        ST_SEARCH = 8'b00000100,
        ST_SCHK   = 8'b00001000,
        ST_FREE   = 8'b00010000,
        ST_SCAN   = 8'b00100000,
        ST_SCHKF  = 8'b01000000,
        ST_OUT    = 8'b10000000
    } state_t;

    logic [63:0] mem [SLOTS];
    logic [63:0] rdata_reg;
    logic        mem_we;
    logic [SW-1:0] mem_addr;
    logic [63:0] mem_wdata;

    state_t state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [31:0] base_reg;
    logic [63:0] ready_reg, unav_reg;
    logic        active_reg, active_next;
    logic [SW-1:0] start_reg, start_next, end_reg, end_next;
    logic [63:0] applied_reg, applied_next;
    logic [63:0] obs_reg;
    logic        found_reg, found_next;
    logic [SW-1:0] last_reg, last_next;
    logic        rearm_reg, rearm_next, lost_reg, lost_next, pend_reg, pend_next;
    logic        ffound_reg, ffound_next;
    logic [SW-1:0] fidx_reg, fidx_next;
    logic        rv_reg;

    assign cfg_ready = 1'b1;
    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rdata_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            ready_reg <= '0;
            unav_reg  <= 64'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BASE:  base_reg  <= cfg_data[31:0];
                REG_READY: ready_reg <= cfg_data;
                REG_UNAV:  unav_reg  <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        active_next  = active_reg;
        start_next   = start_reg;
        end_next     = end_reg;
        applied_next = applied_reg;
        found_next   = found_reg;
        last_next    = last_reg;
        rearm_next   = rearm_reg;
        lost_next    = lost_reg;
        pend_next    = pend_reg;
        ffound_next  = ffound_reg;
        fidx_next    = fidx_reg;
        mem_we       = 1'b0;
        mem_addr     = idx_reg[SW-1:0];
        mem_wdata    = ready_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                rearm_next  = 1'b0;
                lost_next   = 1'b0;
                pend_next   = 1'b0;
                ffound_next = 1'b0;
                fidx_next   = '0;
                idx_next    = '0;
                if (start)
                begin
                    state_next = ST_SCAN;
                    unique case (action_t'(action))
                        ACT_SUBMIT:
                        begin
                            if (32'(slot_index) < SLOTS)
                            begin
                                mem_we    = 1'b1;
                                mem_addr  = SW'(slot_index);
                                mem_wdata = stamp_value;
                                end_next  = SW'(slot_index);
                                if (!active_reg)
                                begin
                                    start_next  = SW'(slot_index);
                                    active_next = 1'b1;
                                    rearm_next  = 1'b1;
                                end
                            end
                        end
                        ACT_POLL:
                        begin
                            if (active_reg && !channel_done)
                                pend_next = 1'b1;
                            else if (active_reg)
                            begin
                                found_next = 1'b0;
                                idx_next   = CW'(start_reg);
                                state_next = ST_SEARCH;
                            end
                        end
                        ACT_STOP:
                        begin
                            active_next = 1'b0;
                            idx_next    = '0;
                            last_next   = SW'(LAST);
                            state_next  = ST_FREE;
                        end
                        ACT_SET: applied_next = stamp_value;
                        default: ;
                    endcase
                end
            end
            ST_SEARCH:
            begin
                mem_addr   = idx_reg[SW-1:0];
                state_next = ST_SCHK;
            end
            ST_SCHK:
            begin
                mem_we    = 1'b1;
                mem_wdata = unav_reg;
                if (rdata_reg == obs_reg)
                begin
                    found_next   = 1'b1;
                    last_next    = idx_reg[SW-1:0];
                    applied_next = rdata_reg;
                end
                if (rdata_reg == obs_reg || idx_reg == LAST)
                begin
                    idx_next = '0;
                    if (rdata_reg == obs_reg && idx_reg[SW-1:0] != end_reg)
                    begin
                        start_next  = (idx_reg == LAST) ? '0 : SW'(idx_reg + 1'b1);
                        active_next = 1'b1;
                        rearm_next  = 1'b1;
                        state_next  = ST_SCAN;
                    end
                    else
                    begin
                        if (rdata_reg != obs_reg)
                            lost_next = 1'b1;
                        last_next   = end_reg;
                        active_next = 1'b0;
                        state_next  = ST_FREE;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_FREE:
            begin
                mem_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg[SW-1:0] == last_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                state_next = ST_SCHKF;
            end
            ST_SCHKF:
            begin
                if (!ffound_reg && rdata_reg == ready_reg)
                begin
                    ffound_next = 1'b1;
                    fidx_next   = idx_reg[SW-1:0];
                end
                if (idx_reg == LAST)
                    state_next = ST_OUT;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            idx_reg     <= '0;
            active_reg  <= 1'b0;
            start_reg   <= '0;
            end_reg     <= '0;
            applied_reg <= '0;
            found_reg   <= 1'b0;
            last_reg    <= '0;
            rearm_reg   <= 1'b0;
            lost_reg    <= 1'b0;
            pend_reg    <= 1'b0;
            ffound_reg  <= 1'b0;
            fidx_reg    <= '0;
            rv_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            active_reg  <= active_next;
            start_reg   <= start_next;
            end_reg     <= end_next;
            applied_reg <= applied_next;
            found_reg   <= found_next;
            last_reg    <= last_next;
            rearm_reg   <= rearm_next;
            lost_reg    <= lost_next;
            pend_reg    <= pend_next;
            ffound_reg  <= ffound_next;
            fidx_reg    <= fidx_next;
            rv_reg      <= (state_reg == ST_OUT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
            obs_reg <= observed_stamp;
    end

    // result register
    logic [31:0] sa_addr, ea_addr;
    assign sa_addr = base_reg + 32'(64'(start_reg) * 64'(TABLE_BYTES));
    assign ea_addr = base_reg + 32'(64'(end_reg) * 64'(TABLE_BYTES)) + 32'(TABLE_BYTES - 4);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT)
        begin
            last_applied_stamp   <= applied_reg;
            engine_active        <= active_reg;
            window_start_slot    <= active_reg ? 3'(start_reg) : 3'd0;
            window_end_slot      <= active_reg ? 3'(end_reg) : 3'd0;
            window_start_address <= active_reg ? sa_addr : 32'd0;
            window_end_address   <= active_reg ? ea_addr : 32'd0;
            window_rearmed       <= rearm_reg;
            lost_track           <= lost_reg;
            pending_at_poll      <= pend_reg;
            free_slot            <= 3'(fidx_reg);
            free_slot_found      <= ffound_reg;
        end
    end
    assign result_valid = rv_reg;

`ifndef ASSERT_OFF
    a_result_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |=> result_valid)
        else $error("result strobe missing");
    a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !$past(start && !busy))
        else $error("result overlaps acceptance");
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(pending_at_poll && (lost_track || window_rearmed)))
        else $error("pending with other flags");
    a_lost_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && lost_track) |-> !engine_active)
        else $error("lost track while active");
`endif

endmodule

// ===== tb/config_slot_completion_tracker_checker.sv =====
// checker module: predicts tracker results from observed transactions and compares them
`timescale 1ns / 100ps
module config_slot_completion_tracker_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  action,
    input  logic [2:0]  slot_index,
    input  logic [63:0] stamp_value,
    input  logic        channel_done,
    input  logic [63:0] observed_stamp,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        result_valid,
    input  logic [63:0] last_applied_stamp,
    input  logic        engine_active,
    input  logic [2:0]  window_start_slot,
    input  logic [2:0]  window_end_slot,
    input  logic [31:0] window_start_address,
    input  logic [31:0] window_end_address,
    input  logic        window_rearmed,
    input  logic        lost_track,
    input  logic        pending_at_poll,
    input  logic [2:0]  free_slot,
    input  logic        free_slot_found,
    output int          fail_count,
    output int          pending_count
);
    import cst_pkg::*;

    localparam int NSLOT = int'(SLOTS_DEFAULT);
    localparam int TBYTES = int'(TABLE_BYTES_DEFAULT);

    typedef struct packed {
        logic [63:0] applied;
        logic        active;
        logic [2:0]  wstart;
        logic [2:0]  wend;
        logic [31:0] astart;
        logic [31:0] aend;
        logic        rearmed;
        logic        lost;
        logic        pending;
        logic [2:0]  free_idx;
        logic        free_found;
    } status_t;

    logic [31:0] base_addr;
    logic [63:0] ready_mark;
    logic [63:0] unav_mark;
    logic [63:0] slot_tab [NSLOT];
    logic        act_q;
    int          start_q;
    int          end_q;
    logic [63:0] applied_q;
    status_t     status_queue [$];

    function automatic status_t track_step(logic [1:0] act, logic [2:0] slot,
                                           logic [63:0] stamp, logic done,
                                           logic [63:0] obs);
        status_t r;
        int last;
        int i;
        logic found;
        r = '0;
        case (act)
            ACT_SUBMIT:
            begin
                slot_tab[slot] = stamp;
                end_q = int'(slot);
                if (!act_q)
                begin
                    start_q = int'(slot);
                    act_q = 1'b1;
                    r.rearmed = 1'b1;
                end
            end
            ACT_POLL:
            begin
                if (act_q && !done)
                    r.pending = 1'b1;
                else if (act_q)
                begin
                    found = 1'b0;
                    last = 0;
                    for (i = start_q; i < NSLOT && !found; i++)
                    begin
                        if (slot_tab[i] == obs)
                        begin
                            found = 1'b1;
                            last = i;
                            applied_q = slot_tab[i];
                        end
                        slot_tab[i] = unav_mark;
                    end
                    if (!found)
                    begin
                        r.lost = 1'b1;
                        last = end_q;
                    end
                    act_q = 1'b0;
                    if (last == end_q)
                    begin
                        for (i = 0; i <= last; i++)
                            slot_tab[i] = ready_mark;
                    end
                    else
                    begin
                        start_q = (last + 1) % NSLOT;
                        act_q = 1'b1;
                        r.rearmed = 1'b1;
                    end
                end
            end
            ACT_STOP:
            begin
                act_q = 1'b0;
                for (i = 0; i < NSLOT; i++)
                    slot_tab[i] = ready_mark;
            end
            default:
                applied_q = stamp;
        endcase
        for (i = NSLOT - 1; i >= 0; i--)
        begin
            if (slot_tab[i] == ready_mark)
            begin
                r.free_found = 1'b1;
                r.free_idx = 3'(i);
            end
        end
        r.applied = applied_q;
        r.active = act_q;
        if (act_q)
        begin
            r.wstart = 3'(start_q);
            r.wend = 3'(end_q);
            r.astart = base_addr + 32'(start_q * TBYTES);
            r.aend = base_addr + 32'(end_q * TBYTES) + 32'(TBYTES - 4);
        end
        return r;
    endfunction

    task automatic compare_field(string name, logic [63:0] expv, logic [63:0] actv);
        if (expv !== actv)
        begin
            $display("%0t mismatch %s expected %h actual %h", $time, name, expv, actv);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        status_t e;
        if (!rst_n)
        begin
            fail_count = 0;
            base_addr = '0;
            ready_mark = '0;
            unav_mark = 64'd1;
            for (int i = 0; i < NSLOT; i++)
                slot_tab[i] = '0;
            act_q = 1'b0;
            start_q = 0;
            end_q = 0;
            applied_q = '0;
            status_queue.delete();
            pending_count = 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (status_queue.size() == 0)
                begin
                    $display("%0t unexpected result transaction", $time);
                    fail_count++;
                end
                else
                begin
                    e = status_queue.pop_front();
                    compare_field("last_applied_stamp", e.applied, last_applied_stamp);
                    compare_field("engine_active", 64'(e.active), 64'(engine_active));
                    compare_field("window_start_slot", 64'(e.wstart),
                                  64'(window_start_slot));
                    compare_field("window_end_slot", 64'(e.wend), 64'(window_end_slot));
                    compare_field("window_start_address", 64'(e.astart),
                                  64'(window_start_address));
                    compare_field("window_end_address", 64'(e.aend),
                                  64'(window_end_address));
                    compare_field("window_rearmed", 64'(e.rearmed), 64'(window_rearmed));
                    compare_field("lost_track", 64'(e.lost), 64'(lost_track));
                    compare_field("pending_at_poll", 64'(e.pending), 64'(pending_at_poll));
                    compare_field("free_slot", 64'(e.free_idx), 64'(free_slot));
                    compare_field("free_slot_found", 64'(e.free_found),
                                  64'(free_slot_found));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BASE:  base_addr = cfg_data[31:0];
                    REG_READY: ready_mark = cfg_data;
                    REG_UNAV:  unav_mark = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                status_queue.push_back(track_step(action, slot_index, stamp_value,
                                                  channel_done, observed_stamp));
            pending_count = status_queue.size();
        end
    end
endmodule

// ===== tb/config_slot_completion_tracker_tb.sv =====
// testbench top: stimulus for the slot completion tracker and the final verdict
`timescale 1ns / 100ps
module config_slot_completion_tracker_tb;
    import cst_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  action;
    logic [2:0]  slot_index;
    logic [63:0] stamp_value;
    logic        channel_done;
    logic [63:0] observed_stamp;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        result_valid;
    logic [63:0] last_applied_stamp;
    logic        engine_active;
    logic [2:0]  window_start_slot;
    logic [2:0]  window_end_slot;
    logic [31:0] window_start_address;
    logic [31:0] window_end_address;
    logic        window_rearmed;
    logic        lost_track;
    logic        pending_at_poll;
    logic [2:0]  free_slot;
    logic        free_slot_found;
    int          fail_count;
    int          pending_count;
    int          cycle_count;
    int          idle_pct;
    logic [63:0] submitted [8];

    config_slot_completion_tracker DUT (.*);
    config_slot_completion_tracker_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic issue(logic [1:0] act, logic [2:0] slot, logic [63:0] stamp,
                         logic done, logic [63:0] obs);
        while ($urandom_range(99) < idle_pct)
            @(posedge clk);
        start <= 1'b1;
        action <= act;
        slot_index <= slot;
        stamp_value <= stamp;
        channel_done <= done;
        observed_stamp <= obs;
        if (act == ACT_SUBMIT)
            submitted[slot] = stamp;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_count != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [63:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // well-formed window: submits then polls that mostly observe a stamp from the submitted table
    task automatic random_window();
        int n;
        int s;
        logic [63:0] obs;
        n = $urandom_range(1, 4);
        s = $urandom_range(7);
        for (int k = 0; k < n; k++)
        begin
            issue(ACT_SUBMIT, 3'(s), rand64(), 1'($urandom_range(1)), rand64());
            s = (s + $urandom_range(1, 2)) % 8;
        end
        for (int k = 0; k < 3; k++)
        begin
            obs = ($urandom_range(9) < 8) ? submitted[$urandom_range(7)] : rand64();
            issue(ACT_POLL, 3'($urandom_range(7)), rand64(), $urandom_range(4) != 0, obs);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_SUBMIT;
        slot_index = '0;
        stamp_value = '0;
        channel_done = 1'b0;
        observed_stamp = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_BASE;
        cfg_data = '0;
        idle_pct = 0;
        for (int i = 0; i < 8; i++)
            submitted[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle poll, pending poll, match, restart, lost track, stop, set, register writes
        issue(ACT_POLL, 3'd0, '0, 1'b1, '0);
        issue(ACT_SUBMIT, 3'd7, '1, 1'b0, '0);
        issue(ACT_POLL, 3'd0, '0, 1'b0, '0);
        issue(ACT_POLL, 3'd0, '0, 1'b1, '1);
        issue(ACT_SUBMIT, 3'd0, 64'd5, 1'b0, '0);
        issue(ACT_SUBMIT, 3'd3, 64'd6, 1'b0, '0);
        issue(ACT_SUBMIT, 3'd3, 64'd7, 1'b0, '0);
        issue(ACT_POLL, 3'd0, '0, 1'b1, 64'd5);
        issue(ACT_POLL, 3'd0, '0, 1'b1, 64'd99);
        issue(ACT_SUBMIT, 3'd6, 64'd8, 1'b0, '0);
        issue(ACT_SUBMIT, 3'd7, 64'd9, 1'b0, '0);
        issue(ACT_POLL, 3'd0, '0, 1'b1, 64'd8);
        issue(ACT_STOP, 3'd0, '0, 1'b0, '0);
        issue(ACT_SET, 3'd0, '1, 1'b1, '1);
        issue(ACT_SET, 3'd0, '0, 1'b0, '0);
        write_reg(REG_BASE, 64'hFFFF_FF00);
        write_reg(REG_READY, 64'd1);
        write_reg(REG_UNAV, 64'd0);
        issue(ACT_SUBMIT, 3'd7, 64'd3, 1'b0, '0);
        issue(ACT_POLL, 3'd0, '0, 1'b1, 64'd3);
        issue(ACT_STOP, 3'd0, '0, 1'b0, '0);
        write_reg(REG_BASE, '1);
        write_reg(REG_READY, '1);
        write_reg(REG_UNAV, '1);
        issue(ACT_SUBMIT, 3'd2, '1, 1'b0, '0);
        issue(ACT_POLL, 3'd0, '0, 1'b1, '1);

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 9 : (phase == 1) ? 75 : 0;
            write_reg(REG_BASE, rand64());
            write_reg(REG_READY, ($urandom_range(1)) ? 64'd0 : rand64());
            write_reg(REG_UNAV, ($urandom_range(1)) ? 64'd1 : rand64());
            for (int k = 0; k < 90; k++)
            begin
                if ($urandom_range(4) == 0)
                    issue(2'($urandom_range(3)), 3'($urandom_range(7)), rand64(),
                          1'($urandom_range(1)), rand64());
                else
                    random_window();
                if ($urandom_range(9) == 0)
                    issue(ACT_STOP, 3'd0, '0, 1'b0, '0);
            end
            drain();
        end

        drain();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
